[rtl/core/mbgd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_pkg
// Types and constants shared by the multi-button gesture detector files.
// ----------------------------------------------------------------------------
package mbgd_pkg;

    localparam int KEY_W      = 5;
    localparam int TIME_W     = 16;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_ENABLE   = 2'd2;

    localparam logic [TIME_W-1:0] CLICK_WINDOW_RST = 16'd600;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic              DBL_ENABLE_RST   = 1'b1;

    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_DBLPRESS = 3'd3,
        PH_LPRESS   = 3'd4
    } t_phase;

    typedef enum logic [CODE_W-1:0] {
        EV_RELEASE = 3'd0,
        EV_CLICK   = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_LSTART  = 3'd3,
        EV_LBUSY   = 3'd4,
        EV_LSTOP   = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EXEC = 2'd2,
        ST_EMIT = 2'd3
    } t_state;

    // one slot as read from the slot file
    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        t_phase            phase;
        logic [TIME_W-1:0] press_time;
    } t_slot_rd;

    // write request into the slot file
    typedef struct packed {
        logic              en;
        logic [KEY_W-1:0]  key;
        t_phase            phase;
        logic              time_en;
        logic [TIME_W-1:0] press_time;
    } t_slot_wr;

    // outcome of one gesture step
    typedef struct packed {
        t_phase     next_phase;
        logic       set_time;
        logic [1:0] ev_cnt;
        t_event     ev0;
        t_event     ev1;
    } t_step;

endpackage

[rtl/core/mbgd_sample_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_sample_if
// Valid/ready channel carrying one key sample.
// ----------------------------------------------------------------------------
interface mbgd_sample_if;
    logic                        valid;
    logic                        ready;
    logic [mbgd_pkg::KEY_W-1:0]  button_index;
    logic                        pressed;
    logic [mbgd_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output button_index, output pressed, output now_ms,
                    input ready);
    modport sink   (input valid, input button_index, input pressed, input now_ms,
                    output ready);
endinterface

[rtl/core/mbgd_event_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_event_if
// Valid/ready channel carrying one gesture event.
// ----------------------------------------------------------------------------
interface mbgd_event_if;
    logic                        valid;
    logic                        ready;
    logic [mbgd_pkg::KEY_W-1:0]  event_button;
    logic [mbgd_pkg::CODE_W-1:0] event_code;
    logic                        last_event;

    modport source (output valid, output event_button, output event_code,
                    output last_event, input ready);
    modport sink   (input valid, input event_button, input event_code,
                    input last_event, output ready);
endinterface

[rtl/core/mbgd_slot_file.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_slot_file
// Slot pool: key, phase and press time per slot, one read and one write port
// at the same index.
// ----------------------------------------------------------------------------
module mbgd_slot_file #(
    parameter int NUM_SLOTS = 8,
    parameter int IDX_W     = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IDX_W-1:0]    i_idx,
    input  mbgd_pkg::t_slot_wr  i_wr,
    output mbgd_pkg::t_slot_rd  o_rd
);

    logic [NUM_SLOTS-1:0]        r_used;
    logic [mbgd_pkg::KEY_W-1:0]  r_key   [NUM_SLOTS];
    mbgd_pkg::t_phase            r_phase [NUM_SLOTS];
    logic [mbgd_pkg::TIME_W-1:0] r_time  [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en) begin
            r_used[i_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_idx]   <= i_wr.key;
            r_phase[i_idx] <= i_wr.phase;
            if (i_wr.time_en) begin
                r_time[i_idx] <= i_wr.press_time;
            end
        end
    end

    // an unused slot reads as START; its payload is don't-care
    always_comb begin
        o_rd.used       = r_used[i_idx];
        o_rd.key        = r_key[i_idx];
        o_rd.phase      = r_used[i_idx] ? r_phase[i_idx] : mbgd_pkg::PH_START;
        o_rd.press_time = r_time[i_idx];
    end

endmodule

[rtl/core/mbgd_gesture_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_gesture_step
// Phase transition and event selection for one slot, from the wrapped
// elapsed time since press start.
// ----------------------------------------------------------------------------
module mbgd_gesture_step (
    input  mbgd_pkg::t_phase            i_phase,
    input  logic                        i_down,
    input  logic [mbgd_pkg::TIME_W-1:0] i_now,
    input  logic [mbgd_pkg::TIME_W-1:0] i_press_time,
    input  logic [mbgd_pkg::TIME_W-1:0] i_click_window,
    input  logic [mbgd_pkg::TIME_W-1:0] i_long_press,
    input  logic                        i_dbl_en,
    output mbgd_pkg::t_step             o_step
);

    logic [mbgd_pkg::TIME_W-1:0] elapsed;

    assign elapsed = i_now - i_press_time;

    always_comb begin
        o_step.next_phase = i_phase;
        o_step.set_time   = 1'b0;
        o_step.ev_cnt     = 2'd0;
        o_step.ev0        = mbgd_pkg::EV_RELEASE;
        o_step.ev1        = mbgd_pkg::EV_RELEASE;
        case (i_phase)
            mbgd_pkg::PH_PRESSED: begin
                if (!i_down) begin
                    o_step.next_phase = mbgd_pkg::PH_RELEASED;
                    o_step.ev_cnt     = 2'd1;
                end else if (elapsed > i_long_press) begin
                    o_step.next_phase = mbgd_pkg::PH_LPRESS;
                    o_step.ev_cnt     = 2'd2;
                    o_step.ev0        = mbgd_pkg::EV_LSTART;
                    o_step.ev1        = mbgd_pkg::EV_LBUSY;
                end
            end
            mbgd_pkg::PH_RELEASED: begin
                if (!i_dbl_en || (elapsed > i_click_window)) begin
                    o_step.next_phase = mbgd_pkg::PH_START;
                    o_step.ev_cnt     = 2'd1;
                    o_step.ev0        = mbgd_pkg::EV_CLICK;
                end else if (i_down) begin
                    o_step.next_phase = mbgd_pkg::PH_DBLPRESS;
                    o_step.set_time   = 1'b1;
                end
            end
            mbgd_pkg::PH_DBLPRESS: begin
                if (!i_down) begin
                    o_step.next_phase = mbgd_pkg::PH_START;
                    o_step.ev_cnt     = 2'd2;
                    o_step.ev1        = mbgd_pkg::EV_DOUBLE;
                end
            end
            mbgd_pkg::PH_LPRESS: begin
                if (!i_down) begin
                    o_step.next_phase = mbgd_pkg::PH_START;
                    o_step.ev_cnt     = 2'd2;
                    o_step.ev1        = mbgd_pkg::EV_LSTOP;
                end else begin
                    o_step.ev_cnt     = 2'd1;
                    o_step.ev0        = mbgd_pkg::EV_LBUSY;
                end
            end
            default: begin
                // START and unreachable codes
                o_step.next_phase = i_down ? mbgd_pkg::PH_PRESSED : mbgd_pkg::PH_START;
                o_step.set_time   = i_down;
            end
        endcase
    end

endmodule

[rtl/core/multi_button_gesture_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_gesture_detector
// Click / double click / long press detection for up to NUM_SLOTS keys.
//
// Channel    Dir  Handshake        Word
// i_sample   in   valid/ready      button_index, pressed, now_ms
// o_event    out  valid/ready      event_button, event_code, last_event
// i_cfg_*    in   write enable     register index, 16-bit data
//
// Per sample: accept, a scan of up to NUM_SLOTS slots, update, then 0..2
// events. The scan reads one slot per cycle through the single key
// comparator and stops early on a key match.
// Reset clears all slots to unused and restores the register defaults.
// Samples are not taken while a sample is in work or its events wait; a
// stalled event holds until taken.
// ----------------------------------------------------------------------------
module multi_button_gesture_detector #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mbgd_sample_if.sink                     i_sample,
    mbgd_event_if.source                    o_event,
    input  logic                            i_cfg_we,
    input  logic [mbgd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mbgd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    mbgd_pkg::t_state            r_state, n_state;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [mbgd_pkg::KEY_W-1:0]  r_key;
    logic                        r_down;
    logic [mbgd_pkg::TIME_W-1:0] r_now;
    logic                        r_free_found, n_free_found;
    logic [IDX_W-1:0]            r_free_idx, n_free_idx;
    logic                        r_start_found, n_start_found;
    logic [IDX_W-1:0]            r_start_idx, n_start_idx;
    mbgd_pkg::t_event            r_ev_cur, n_ev_cur;
    mbgd_pkg::t_event            r_ev_next, n_ev_next;
    logic                        r_ev_two, n_ev_two;

    logic [mbgd_pkg::TIME_W-1:0] r_click_window;
    logic [mbgd_pkg::TIME_W-1:0] r_long_press;
    logic                        r_dbl_en;

    mbgd_pkg::t_slot_rd slot_rd;
    mbgd_pkg::t_slot_wr slot_wr;
    mbgd_pkg::t_step    step;
    logic               in_acc;
    logic               key_hit;

    mbgd_slot_file #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_slot_file (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_wr    (slot_wr),
        .o_rd    (slot_rd)
    );

    mbgd_gesture_step u_step (
        .i_phase        (slot_rd.phase),
        .i_down         (r_down),
        .i_now          (r_now),
        .i_press_time   (slot_rd.press_time),
        .i_click_window (r_click_window),
        .i_long_press   (r_long_press),
        .i_dbl_en       (r_dbl_en),
        .o_step         (step)
    );

    assign i_sample.ready     = (r_state == mbgd_pkg::ST_IDLE);
    assign in_acc             = i_sample.valid && i_sample.ready;
    assign o_event.valid      = (r_state == mbgd_pkg::ST_EMIT);
    assign o_event.event_button = r_key;
    assign o_event.event_code = r_ev_cur;
    assign o_event.last_event = !r_ev_two;
    assign key_hit            = slot_rd.used && (slot_rd.key == r_key);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_window <= mbgd_pkg::CLICK_WINDOW_RST;
            r_long_press   <= mbgd_pkg::LONG_PRESS_RST;
            r_dbl_en       <= mbgd_pkg::DBL_ENABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbgd_pkg::CFG_CLICK_WINDOW: r_click_window <= i_cfg_data;
                mbgd_pkg::CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                mbgd_pkg::CFG_DBL_ENABLE:   r_dbl_en       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbgd_pkg::ST_IDLE;
            r_ev_two <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ev_two <= n_ev_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key  <= i_sample.button_index;
            r_down <= i_sample.pressed;
            r_now  <= i_sample.now_ms;
        end
        r_idx         <= n_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_start_found <= n_start_found;
        r_start_idx   <= n_start_idx;
        r_ev_cur      <= n_ev_cur;
        r_ev_next     <= n_ev_next;
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_start_found = r_start_found;
        n_start_idx   = r_start_idx;
        n_ev_cur      = r_ev_cur;
        n_ev_next     = r_ev_next;
        n_ev_two      = r_ev_two;
        slot_wr.en         = 1'b0;
        slot_wr.key        = r_key;
        slot_wr.phase      = step.next_phase;
        slot_wr.time_en    = step.set_time;
        slot_wr.press_time = r_now;

        case (r_state)
            mbgd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_idx         = '0;
                    n_free_found  = 1'b0;
                    n_start_found = 1'b0;
                    n_state       = mbgd_pkg::ST_SCAN;
                end
            end
            mbgd_pkg::ST_SCAN: begin
                if (!slot_rd.used && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if ((slot_rd.phase == mbgd_pkg::PH_START) && !r_start_found) begin
                    n_start_found = 1'b1;
                    n_start_idx   = r_idx;
                end
                if (key_hit) begin
                    // own slot found: hold index, update it next
                    n_state = mbgd_pkg::ST_EXEC;
                end else if (r_idx == LAST_IDX) begin
                    if (!r_down) begin
                        n_state = mbgd_pkg::ST_IDLE;
                    end else if (n_free_found) begin
                        n_idx   = n_free_idx;
                        n_state = mbgd_pkg::ST_EXEC;
                    end else if (n_start_found) begin
                        n_idx   = n_start_idx;
                        n_state = mbgd_pkg::ST_EXEC;
                    end else begin
                        // pool exhausted: drop
                        n_state = mbgd_pkg::ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mbgd_pkg::ST_EXEC: begin
                slot_wr.en = 1'b1;
                n_ev_cur   = step.ev0;
                n_ev_next  = step.ev1;
                n_ev_two   = (step.ev_cnt == 2'd2);
                n_state    = (step.ev_cnt == 2'd0) ? mbgd_pkg::ST_IDLE : mbgd_pkg::ST_EMIT;
            end
            mbgd_pkg::ST_EMIT: begin
                if (o_event.ready) begin
                    if (r_ev_two) begin
                        // advance to the second word
                        n_ev_cur = r_ev_next;
                        n_ev_two = 1'b0;
                    end else begin
                        n_state = mbgd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mbgd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mbgd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbgd_checker
// Port-level checks on the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module mbgd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [mbgd_pkg::KEY_W-1:0]  i_out_button,
    input logic [mbgd_pkg::CODE_W-1:0] i_out_code,
    input logic                        i_out_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_button) && $stable(i_out_code)
             && $stable(i_out_last)))
        else $error("event word changed while stalled");

    // one sample at a time: no intake while events are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("sample taken while events pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accept");

    // the second event of a sample follows at once, for the same key
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=>
            (i_out_valid && $stable(i_out_button)))
        else $error("second event missing after non-final event");

endmodule

bind multi_button_gesture_detector mbgd_checker u_mbgd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_event.valid),
    .i_out_ready  (o_event.ready),
    .i_out_button (o_event.event_button),
    .i_out_code   (o_event.event_code),
    .i_out_last   (o_event.last_event)
);
